>>> rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/acahc_pkg.sv
// Package with the types, constants and threshold function of the hysteresis comparator.
package acahc_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int RATIO_BITS  = 11;
    localparam int RATIO_SHIFT = 10;
    localparam int TICKS_BITS  = 16;
    localparam int COUNT_BITS  = 17;
    localparam int CFG_IDX_BITS = 2;
    localparam int PROD_BITS   = SAMPLE_BITS + RATIO_BITS;
    localparam int SUM_BITS    = SAMPLE_BITS + 2;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

    localparam logic [TICKS_BITS-1:0] LEARN_TICKS_RST = TICKS_BITS'(5000);
    localparam logic [RATIO_BITS-1:0] LOW_RATIO_RST   = RATIO_BITS'(307);
    localparam logic [RATIO_BITS-1:0] HIGH_RATIO_RST  = RATIO_BITS'(717);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LEARN_TICKS = 2'd0,
        CFG_LOW_RATIO   = 2'd1,
        CFG_HIGH_RATIO  = 2'd2
    } t_cfg_idx;

    // Item kinds carried in the action field.
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    typedef struct packed {
        logic                   action;
        logic [SAMPLE_BITS-1:0] sample_ch0;
        logic [SAMPLE_BITS-1:0] sample_ch1;
    } t_in_req;

    typedef struct packed {
        logic level_ch0;
        logic level_ch1;
        logic learning;
    } t_out_req;

    // Per-lane control from the sequencing logic in the top level.
    typedef struct packed {
        logic smp_en;
        logic fix;
        logic learning;
    } t_lane_ctl;

    // Threshold = base + truncated (range * ratio) / 1024, saturated to the sample range.
    function automatic logic [SAMPLE_BITS-1:0] scale_thr(
        input logic [SAMPLE_BITS-1:0] base,
        input logic [SAMPLE_BITS-1:0] range,
        input logic [RATIO_BITS-1:0]  ratio
    );
        logic [PROD_BITS-1:0] prod;
        logic [SUM_BITS-1:0]  sum;
        prod = PROD_BITS'(range) * PROD_BITS'(ratio);
        sum  = SUM_BITS'(base) + SUM_BITS'(prod >> RATIO_SHIFT);
        if (sum > SUM_BITS'(SAMPLE_MAX)) begin
            return SAMPLE_MAX;
        end
        return sum[SAMPLE_BITS-1:0];
    endfunction

endpackage

>>> rtl/acahc_lane.sv
// One channel lane: extreme tracking, threshold computation and Schmitt trigger.
module acahc_lane
    import acahc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_lane_ctl              i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [RATIO_BITS-1:0]  i_low_ratio,
    input  logic [RATIO_BITS-1:0]  i_high_ratio,
    output logic                   o_level
);

    logic [SAMPLE_BITS-1:0] r_min, n_min;
    logic [SAMPLE_BITS-1:0] r_max, n_max;
    logic [SAMPLE_BITS-1:0] r_thr_lo, n_thr_lo;
    logic [SAMPLE_BITS-1:0] r_thr_hi, n_thr_hi;
    logic                   r_level, n_level;
    logic [SAMPLE_BITS-1:0] range;

    // A channel that saw no sample has max below min; its range counts as zero.
    assign range = (r_max >= r_min) ? (r_max - r_min) : '0;

    // Next-state logic for extremes, thresholds and the output level.
    always_comb begin
        n_min    = r_min;
        n_max    = r_max;
        n_thr_lo = r_thr_lo;
        n_thr_hi = r_thr_hi;
        n_level  = r_level;
        if (i_ctl.fix) begin
            n_thr_lo = scale_thr(r_min, range, i_low_ratio);
            n_thr_hi = scale_thr(r_min, range, i_high_ratio);
        end
        if (i_ctl.smp_en) begin
            if (i_ctl.learning) begin
                if (i_sample > r_max) n_max = i_sample;
                if (i_sample < r_min) n_min = i_sample;
            end else if (i_sample >= r_thr_hi) begin
                n_level = 1'b1;
            end else if (i_sample <= r_thr_lo) begin
                n_level = 1'b0;
            end
        end
    end

    // Lane state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min    <= SAMPLE_MAX;
            r_max    <= '0;
            r_thr_lo <= '0;
            r_thr_hi <= '0;
            r_level  <= 1'b0;
        end else begin
            r_min    <= n_min;
            r_max    <= n_max;
            r_thr_lo <= n_thr_lo;
            r_thr_hi <= n_thr_hi;
            r_level  <= n_level;
        end
    end

    // The level after the current request goes to the merging stage.
    assign o_level = n_level;

endmodule

>>> rtl/acahc_merge.sv
// Merging stage: gathers the lane levels into a result and buffers it with a skid register.
module acahc_merge
    import acahc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  logic     i_level_ch0,
    input  logic     i_level_ch1,
    input  logic     i_learning,
    output logic     o_full,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_data
);

    t_out_req r_main, n_main;
    t_out_req r_skid, n_skid;
    logic     r_main_vld, n_main_vld;
    logic     r_skid_vld, n_skid_vld;
    t_out_req res;
    logic     pop;

    assign res = '{level_ch0: i_level_ch0, level_ch1: i_level_ch1, learning: i_learning};
    assign pop = r_main_vld && !i_out_stall;

    // Main register feeds the port; the skid register catches a request
    // that arrives while the main one is held.
    always_comb begin
        n_main     = r_main;
        n_skid     = r_skid;
        n_main_vld = r_main_vld;
        n_skid_vld = r_skid_vld;
        if (pop) begin
            n_main_vld = r_skid_vld;
            n_main     = r_skid;
            n_skid_vld = 1'b0;
        end
        if (i_push) begin
            if (!r_main_vld || pop) begin
                n_main     = res;
                n_main_vld = 1'b1;
            end else begin
                n_skid     = res;
                n_skid_vld = 1'b1;
            end
        end
    end

    // Valid flags are reset; payloads are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_main_vld <= n_main_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_full      = r_skid_vld;
    assign o_out_valid = r_main_vld;
    assign o_out_data  = r_main;

endmodule

>>> rtl/auto_calibrating_hysteresis_comparator.sv
// Top level of the two-channel auto-calibrating hysteresis comparator.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): each request is either
// a sample pair (action 0) or a one-millisecond tick (action 1). A request is
// taken at a clock edge with i_in_valid high and o_in_stall low.
// Output channel (o_out_valid / i_out_stall / o_out_data): exactly one result
// per request, in order, holding both channel levels and the learning flag.
// Configuration channel (i_cfg_valid / o_cfg_ready): index 0 learn_ticks,
// 1 low_ratio, 2 high_ratio; o_cfg_ready is always high. Write only when idle.
// A taken request's result enters the output register, or the skid register
// if the output is held. Throughput: one request per cycle while o_in_stall
// is low; both lanes and the tick counter update in the cycle it is taken.
// When the receiver stalls, results collect in the output register and one
// skid register; o_in_stall rises once both are occupied.
// Synchronous reset restores the register defaults, restarts learning and
// empties the output buffer.
module auto_calibrating_hysteresis_comparator
    import acahc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in_req                 i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out_req                o_out_data,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [TICKS_BITS-1:0]   i_cfg_data
);

    logic [TICKS_BITS-1:0] r_learn_ticks;
    logic [RATIO_BITS-1:0] r_low_ratio;
    logic [RATIO_BITS-1:0] r_high_ratio;
    logic [COUNT_BITS-1:0] r_tick_cnt, n_tick_cnt;
    logic                  r_learning, n_learning;
    logic                  accept;
    logic                  tick;
    logic                  fix;
    logic                  full;
    logic                  level_ch0;
    logic                  level_ch1;
    t_lane_ctl             lane_ctl;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;
    assign accept      = i_in_valid && !full;
    assign tick        = accept && (i_in_data.action == ACT_TICK);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn_ticks <= LEARN_TICKS_RST;
            r_low_ratio   <= LOW_RATIO_RST;
            r_high_ratio  <= HIGH_RATIO_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LEARN_TICKS: r_learn_ticks <= i_cfg_data;
                CFG_LOW_RATIO:   r_low_ratio   <= i_cfg_data[RATIO_BITS-1:0];
                CFG_HIGH_RATIO:  r_high_ratio  <= i_cfg_data[RATIO_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Tick counting; thresholds are fixed on the tick that passes learn_ticks.
    always_comb begin
        n_tick_cnt = r_tick_cnt;
        n_learning = r_learning;
        fix        = 1'b0;
        if (tick && r_learning) begin
            n_tick_cnt = r_tick_cnt + COUNT_BITS'(1);
            if (n_tick_cnt > COUNT_BITS'(r_learn_ticks)) begin
                fix        = 1'b1;
                n_learning = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_cnt <= '0;
            r_learning <= 1'b1;
        end else begin
            r_tick_cnt <= n_tick_cnt;
            r_learning <= n_learning;
        end
    end

    assign lane_ctl = '{
        smp_en:   accept && (i_in_data.action == ACT_SAMPLE),
        fix:      fix,
        learning: r_learning
    };

    // One lane per channel.
    acahc_lane u_lane0 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (lane_ctl),
        .i_sample     (i_in_data.sample_ch0),
        .i_low_ratio  (r_low_ratio),
        .i_high_ratio (r_high_ratio),
        .o_level      (level_ch0)
    );

    acahc_lane u_lane1 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (lane_ctl),
        .i_sample     (i_in_data.sample_ch1),
        .i_low_ratio  (r_low_ratio),
        .i_high_ratio (r_high_ratio),
        .o_level      (level_ch1)
    );

    // Result assembly and output buffering.
    acahc_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_level_ch0 (level_ch0),
        .i_level_ch1 (level_ch1),
        .i_learning  (n_learning),
        .o_full      (full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> rtl/acahc_checker.sv
// Port-level checker for the hysteresis comparator and its bind statement.
`include "assert_macros.svh"

module acahc_checker
    import acahc_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_in_stall,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_out_req o_out_data
);

    // A stalled result stays valid.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall |=> o_out_valid, "stalled result dropped")

    // A stalled result keeps its payload.
    `ASSERT_CLK(a_out_stable, i_clk, i_rst_n,
        o_out_valid && i_out_stall |=> $stable(o_out_data), "stalled result changed")

    // Once learning has ended it never resumes without a reset.
    `ASSERT_CLK(a_learn_once, i_clk, i_rst_n,
        o_out_valid && !o_out_data.learning |=> !(o_out_valid && o_out_data.learning),
        "learning resumed")

    // Input back-pressure only appears after the output was held.
    `ASSERT_CLK(a_stall_cause, i_clk, i_rst_n,
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall),
        "input stalled without output stall")

endmodule

bind auto_calibrating_hysteresis_comparator acahc_checker u_acahc_checker (.*);
